>>> src/twde_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// twde_pkg
// Shared types and constants of the touch wheel event decoder.
// ----------------------------------------------------------------------------
package twde_pkg;

  localparam int TWDE_TIME_BITS = 32;

  localparam int NUM_BUTTONS = 5;
  localparam int RUN_BITS    = 8;

  // Pending result slots, emitted from the lowest slot up.
  localparam int RUN_WHEEL_PRESS = 5;
  localparam int RUN_WHEEL_REL   = 6;
  localparam int RUN_NOISE       = 7;

  // Key codes.
  localparam logic [2:0] KEY_SELECT     = 3'd0;
  localparam logic [2:0] KEY_MENU       = 3'd1;
  localparam logic [2:0] KEY_PLAY       = 3'd2;
  localparam logic [2:0] KEY_NEXT       = 3'd3;
  localparam logic [2:0] KEY_PREV       = 3'd4;
  localparam logic [2:0] KEY_WHEEL_FWD  = 3'd5;
  localparam logic [2:0] KEY_WHEEL_BACK = 3'd6;

  // Status word decode.
  localparam logic [31:0] PKT_MASK     = 32'h8000_00ff;
  localparam logic [31:0] PKT_BUTTON   = 32'h8000_001a;
  localparam logic [31:0] PKT_POSITION = 32'h8000_003a;
  localparam int          TOUCH_BIT    = 30;
  localparam logic [27:0] NOISE_ALL    = 28'hfff_ffff;
  localparam logic [27:0] NOISE_ODD    = 28'h555_5555;
  localparam logic [27:0] NOISE_EVEN   = 28'haaa_aaaa;

  // Status bit of each button, indexed by key code.
  localparam int BTN_BIT [NUM_BUTTONS] = '{8, 12, 11, 9, 10};

  // Register indexes and reset values.
  localparam logic [1:0] REG_WHEEL_POSITIONS = 2'd0;
  localparam logic [1:0] REG_STEP_THRESHOLD  = 2'd1;
  localparam logic [1:0] REG_IDLE_TIMEOUT    = 2'd2;

  localparam logic [6:0]  RST_WHEEL_POSITIONS = 7'd96;
  localparam logic [6:0]  RST_STEP_THRESHOLD  = 7'd12;
  localparam logic [31:0] RST_IDLE_TIMEOUT    = 32'd500000;

  typedef struct packed {
    logic [6:0]  wheel_positions;
    logic [6:0]  step_threshold;
    logic [31:0] idle_timeout;
  } cfg_t;

  typedef struct packed {
    logic [NUM_BUTTONS-1:0] held_buttons;
    logic [6:0]             wheel_position;
    logic                   position_known;
    logic                   timeout_armed;
  } wheel_state_t;

  typedef struct packed {
    logic [RUN_BITS-1:0]    pend;
    logic [NUM_BUTTONS-1:0] press;
    logic                   back;
  } run_t;

endpackage

>>> src/twde_decode.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// twde_decode
// Decodes one status word against the held state: next state and the set of
// results that the word causes.
// ----------------------------------------------------------------------------
module twde_decode import twde_pkg::*; #(
  parameter int TIME_BITS = TWDE_TIME_BITS
) (
  input  logic [31:0]          status_word,
  input  logic [31:0]          now_time,
  input  cfg_t                 cfg,
  input  wheel_state_t         st,
  input  logic [TIME_BITS-1:0] last_move_time,
  output wheel_state_t         st_next,
  output logic [TIME_BITS-1:0] last_move_time_next,
  output run_t                 run
);

  logic [63:0]          now64;
  logic [TIME_BITS-1:0] now_v;
  logic [TIME_BITS-1:0] elapsed;
  logic                 timed_out;
  logic [6:0]           ring;
  logic [6:0]           touch;
  logic                 known_t;
  logic                 armed_t;
  logic signed [9:0]    t_s;
  logic signed [9:0]    l_s;
  logic signed [9:0]    r_s;
  logic signed [9:0]    thr_s;
  logic signed [9:0]    adj;
  logic signed [9:0]    delta;
  logic                 go_fwd;
  logic                 go_back;
  logic [NUM_BUTTONS-1:0] fresh;
  logic [27:0]          noise_v;

  assign now64   = 64'(now_time);
  assign now_v   = now64[TIME_BITS-1:0];
  assign elapsed = now_v - last_move_time;
  assign timed_out = st.timeout_armed && (64'(elapsed) > 64'(cfg.idle_timeout));
  assign known_t = st.position_known && !timed_out;
  assign armed_t = st.timeout_armed && !timed_out;

  assign ring  = (cfg.wheel_positions < 7'd2) ? 7'd2 : cfg.wheel_positions;
  assign touch = (status_word[22:16] > ring - 7'd1) ? ring - 7'd1 : status_word[22:16];

  assign t_s   = $signed({3'b000, touch});
  assign l_s   = $signed({3'b000, st.wheel_position});
  assign r_s   = $signed({3'b000, ring});
  assign thr_s = $signed({3'b000, cfg.step_threshold});

  // Take the shorter way round the ring.
  always_comb begin
    adj = t_s;
    if (t_s > l_s) begin
      if (t_s - l_s > r_s + l_s - t_s) adj = t_s - r_s;
    end else begin
      if (l_s - t_s > r_s + t_s - l_s) adj = t_s + r_s;
    end
  end

  assign delta   = adj - l_s;
  assign go_fwd  = delta > thr_s;
  assign go_back = delta < -thr_s;

  always_comb begin
    for (int k = 0; k < NUM_BUTTONS; k++) begin
      fresh[k] = status_word[BTN_BIT[k]];
    end
  end

  assign noise_v = status_word[31:4];

  always_comb begin
    st_next                = st;
    st_next.position_known = known_t;
    st_next.timeout_armed  = armed_t;
    last_move_time_next    = last_move_time;
    run                    = '0;

    if ((status_word & PKT_MASK) == PKT_BUTTON) begin
      run.pend[NUM_BUTTONS-1:0] = fresh ^ st.held_buttons;
      run.press                 = fresh;
      st_next.held_buttons      = fresh;
      if (status_word[TOUCH_BIT]) begin
        if (!known_t) begin
          st_next.wheel_position = touch;
          st_next.position_known = 1'b1;
          st_next.timeout_armed  = 1'b1;
          last_move_time_next    = now_v;
        end else if (go_fwd || go_back) begin
          run.pend[RUN_WHEEL_PRESS] = 1'b1;
          run.pend[RUN_WHEEL_REL]   = 1'b1;
          run.back                  = !go_fwd;
          st_next.wheel_position    = touch;
          st_next.timeout_armed     = 1'b1;
          last_move_time_next       = now_v;
        end else if (st.wheel_position != touch) begin
          st_next.timeout_armed = 1'b1;
          last_move_time_next   = now_v;
        end
      end else begin
        st_next.position_known = 1'b0;
      end
    end else if ((status_word & PKT_MASK) == PKT_POSITION) begin
      st_next.wheel_position = touch;
      st_next.position_known = 1'b1;
    end else if (noise_v == NOISE_ALL || noise_v == NOISE_ODD || noise_v == NOISE_EVEN) begin
      // Noise changes nothing beyond the idle timeout check.
      run.pend[RUN_NOISE]    = 1'b1;
    end
  end

endmodule

>>> src/touch_wheel_event_decoder.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// touch_wheel_event_decoder
// Turns touch controller status words into button and wheel click events.
// ----------------------------------------------------------------------------
// Each accepted status word is decoded in the cycle it is accepted; the
// results it causes (none to seven) are then sent one per cycle, while the
// output is not stalled, through a single output register. The next word is
// accepted in the cycle its predecessor's last result moves into the output
// register, and a result waiting on a stalled output does not block
// acceptance while no earlier result is still queued. Results of one word
// end with tlast. Configuration writes are always taken.
module touch_wheel_event_decoder import twde_pkg::*; #(
  parameter int TIME_BITS = TWDE_TIME_BITS
) (
  input  logic        clk,
  input  logic        rst,
  // cfg: register write
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [1:0]  cfg_index,
  input  logic [31:0] cfg_data,
  // input request
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [63:0] s_tdata,   // [31:0] status_word, [63:32] now_time
  // result
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [7:0]  m_tdata,   // [0] event_valid, [3:1] key_code, [4] pressed,
                                 // [5] reinit_request, [7:6] zero
  output logic        m_tlast    // last_of_run
);

  cfg_t                 cfg;
  wheel_state_t         st;
  wheel_state_t         st_next;
  logic [TIME_BITS-1:0] last_move_time;
  logic [TIME_BITS-1:0] last_move_time_next;
  run_t                 run;
  run_t                 run_next;
  logic [RUN_BITS-1:0]  sel;
  logic [RUN_BITS-1:0]  rem;
  logic                 load;
  logic                 accept;

  logic                 ev_valid_n;
  logic [2:0]           key_n;
  logic                 pressed_n;
  logic                 reinit_n;

  logic                 ev_valid;
  logic [2:0]           key;
  logic                 pressed;
  logic                 reinit;
  logic                 last;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.wheel_positions <= RST_WHEEL_POSITIONS;
      cfg.step_threshold  <= RST_STEP_THRESHOLD;
      cfg.idle_timeout    <= RST_IDLE_TIMEOUT;
    end else if (cfg_valid) begin
      case (cfg_index)
        REG_WHEEL_POSITIONS: cfg.wheel_positions <= cfg_data[6:0];
        REG_STEP_THRESHOLD:  cfg.step_threshold  <= cfg_data[6:0];
        REG_IDLE_TIMEOUT:    cfg.idle_timeout    <= cfg_data;
        default: ;
      endcase
    end
  end

  twde_decode #(
    .TIME_BITS (TIME_BITS)
  ) u_decode (
    .status_word         (s_tdata[31:0]),
    .now_time            (s_tdata[63:32]),
    .cfg                 (cfg),
    .st                  (st),
    .last_move_time      (last_move_time),
    .st_next             (st_next),
    .last_move_time_next (last_move_time_next),
    .run                 (run_next)
  );

  // Next result is the lowest pending slot.
  assign sel  = run.pend & (~run.pend + RUN_BITS'(1));
  assign rem  = run.pend & ~sel;
  assign load = (run.pend != '0) && (!m_tvalid || m_tready);

  assign s_tready = (run.pend == '0) || (load && rem == '0);
  assign accept   = s_tvalid && s_tready;

  always_ff @(posedge clk) begin
    if (rst) begin
      st             <= '0;
      last_move_time <= '0;
      run            <= '0;
    end else begin
      if (accept) begin
        st             <= st_next;
        last_move_time <= last_move_time_next;
        run            <= run_next;
      end else if (load) begin
        run.pend <= rem;
      end
    end
  end

  always_comb begin
    ev_valid_n = 1'b0;
    key_n      = KEY_SELECT;
    pressed_n  = 1'b0;
    reinit_n   = 1'b0;
    for (int i = 0; i < NUM_BUTTONS; i++) begin
      if (sel[i]) begin
        ev_valid_n = 1'b1;
        key_n      = 3'(i);
        pressed_n  = run.press[i];
      end
    end
    if (sel[RUN_WHEEL_PRESS] || sel[RUN_WHEEL_REL]) begin
      ev_valid_n = 1'b1;
      key_n      = run.back ? KEY_WHEEL_BACK : KEY_WHEEL_FWD;
      pressed_n  = sel[RUN_WHEEL_PRESS];
    end
    if (sel[RUN_NOISE]) begin
      reinit_n = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (load) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      ev_valid <= ev_valid_n;
      key      <= key_n;
      pressed  <= pressed_n;
      reinit   <= reinit_n;
      last     <= (rem == '0);
    end
  end

  assign m_tdata = {2'b00, reinit, pressed, key, ev_valid};
  assign m_tlast = last;

endmodule

>>> src/twde_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// twde_checker
// Port-level checks of the touch wheel event decoder.
// ----------------------------------------------------------------------------
module twde_checker import twde_pkg::*; (
  input logic       clk,
  input logic       rst,
  input logic       m_tvalid,
  input logic       m_tready,
  input logic [7:0] m_tdata,
  input logic       m_tlast
);

  // Hold a stalled result.
  a_hold: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tlast))
    else $error("result dropped or changed while stalled");

  // A reinit request stands alone in its run.
  a_reinit_alone: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tdata[5] |-> m_tlast && !m_tdata[0] && m_tdata[3:1] == KEY_SELECT)
    else $error("reinit request not alone");

  // A wheel click press is never the last result of its run.
  a_click_not_last: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tdata[0] && m_tdata[4] &&
    (m_tdata[3:1] == KEY_WHEEL_FWD || m_tdata[3:1] == KEY_WHEEL_BACK) |-> !m_tlast)
    else $error("wheel press ends a run");

  // A taken wheel press is followed at once by its release.
  a_click_release: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tready && m_tdata[0] && m_tdata[4] &&
    (m_tdata[3:1] == KEY_WHEEL_FWD || m_tdata[3:1] == KEY_WHEEL_BACK)
    |=> m_tvalid && m_tdata[0] && !m_tdata[4] && m_tlast &&
        m_tdata[3:1] == $past(m_tdata[3:1]))
    else $error("wheel press without release");

endmodule

bind touch_wheel_event_decoder twde_checker u_twde_checker (
  .clk      (clk),
  .rst      (rst),
  .m_tvalid (m_tvalid),
  .m_tready (m_tready),
  .m_tdata  (m_tdata),
  .m_tlast  (m_tlast)
);
